@@ rtl/json_string_control_escaper_core_macros.svh @@
// Assertion macros for the escaper checker.
`ifndef JSON_STRING_CONTROL_ESCAPER_CORE_MACROS_SVH
`define JSON_STRING_CONTROL_ESCAPER_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define JSCE_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle.
`define JSCE_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/jsce_pkg.sv @@
// Types, character codes and helpers for the JSON string escaper.
package jsce_pkg;

	localparam logic [7:0] CHAR_QUOTE     = 8'h22;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
	localparam logic [7:0] CHAR_LF        = 8'h0a;
	localparam logic [7:0] CHAR_CR        = 8'h0d;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_N         = 8'h6e;
	localparam logic [7:0] CHAR_R         = 8'h72;
	localparam logic [7:0] CHAR_T         = 8'h74;
	localparam logic [7:0] CHAR_U         = 8'h75;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CTRL_LIMIT     = 8'h20;

	// Last sequence index of each expansion.
	localparam logic [2:0] SHORT_LAST_IDX   = 3'd1;
	localparam logic [2:0] UNICODE_LAST_IDX = 3'd5;

	typedef enum logic [1:0] {
		KIND_COPY,
		KIND_SHORT,
		KIND_UNICODE
	} item_kind_t;

	// Decoded expansion: COPY carries the byte, SHORT the escape letter,
	// UNICODE the control code.
	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  data;
	} esc_item_t;

	function automatic logic [7:0] hex_ascii(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = CHAR_ZERO + {4'h0, v};
		end else begin
			r = 8'h57 + {4'h0, v};
		end
		return r;
	endfunction

endpackage

@@ rtl/json_string_control_escaper_core.sv @@
// Top level of the JSON string control-character escaper.
//
// channel  direction  signals                                  payload
// in       sink       in_valid / in_ready                      in_byte, first_of_message
// out      source     out_valid / out_ready                    out_byte, last_of_run
//
// One input byte is taken per cycle while each produces a single output byte and the output is not stalled.
// A two-byte escape or a six-byte unicode escape occupies the output for each of its bytes;
// once the decode stage is full, this holds the input back while the output sequencer's
// byte counter steps through those bytes.
// An input byte passes the decode stage register, then the output sequencer register.
// Reset clears the string and escape tracking and empties both stages.
// With the output stalled, one more input byte is taken into the decode stage.
module json_string_control_escaper_core import jsce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       first_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic      item_valid;
	logic      item_ready;
	esc_item_t item;

	jsce_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.first_of_message (first_of_message),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.item             (item)
	);

	jsce_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

@@ rtl/jsce_decode.sv @@
// Input stage: string tracking and classification of each byte.
module jsce_decode import jsce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       first_of_message,
	output logic       item_valid,
	input  logic       item_ready,
	output esc_item_t  item
);

	logic      inside_q;
	logic      escape_q;
	logic      valid_s1;
	esc_item_t item_s1;

	logic      ins_cur;
	logic      esc_cur;
	logic      ins_nxt;
	logic      esc_nxt;
	esc_item_t dec;
	logic      accept;

	assign in_ready   = !valid_s1 || item_ready;
	assign accept     = in_valid && in_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_comb begin
		ins_cur  = first_of_message ? 1'b0 : inside_q;
		esc_cur  = first_of_message ? 1'b0 : escape_q;
		ins_nxt  = ins_cur;
		esc_nxt  = 1'b0;
		dec.kind = KIND_COPY;
		dec.data = in_byte;
		if (esc_cur) begin
			// copy the escaped byte verbatim
		end else if (!ins_cur) begin
			ins_nxt = (in_byte == CHAR_QUOTE);
		end else if (in_byte == CHAR_BACKSLASH) begin
			esc_nxt = 1'b1;
		end else if (in_byte == CHAR_QUOTE) begin
			ins_nxt = 1'b0;
		end else if (in_byte == CHAR_LF) begin
			dec.kind = KIND_SHORT;
			dec.data = CHAR_N;
		end else if (in_byte == CHAR_CR) begin
			dec.kind = KIND_SHORT;
			dec.data = CHAR_R;
		end else if (in_byte == CHAR_TAB) begin
			dec.kind = KIND_SHORT;
			dec.data = CHAR_T;
		end else if (in_byte < CTRL_LIMIT) begin
			dec.kind = KIND_UNICODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			escape_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			inside_q <= ins_nxt;
			escape_q <= esc_nxt;
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= dec;
		end
	end

endmodule

@@ rtl/jsce_emit.sv @@
// Output sequencer: expands one decoded item into 1, 2 or 6 bytes.
module jsce_emit import jsce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  esc_item_t  item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic       cur_valid_q;
	esc_item_t  cur_item_q;
	logic [2:0] idx_q;
	logic       is_last;

	always_comb begin
		is_last  = 1'b1;
		out_byte = cur_item_q.data;
		unique case (cur_item_q.kind)
			KIND_COPY: begin
				is_last  = 1'b1;
				out_byte = cur_item_q.data;
			end
			KIND_SHORT: begin
				is_last  = (idx_q == SHORT_LAST_IDX);
				out_byte = is_last ? cur_item_q.data : CHAR_BACKSLASH;
			end
			KIND_UNICODE: begin
				is_last = (idx_q == UNICODE_LAST_IDX);
				case (idx_q)
					3'd0:    out_byte = CHAR_BACKSLASH;
					3'd1:    out_byte = CHAR_U;
					3'd2:    out_byte = CHAR_ZERO;
					3'd3:    out_byte = CHAR_ZERO;
					3'd4:    out_byte = hex_ascii(cur_item_q.data[7:4]);
					default: out_byte = hex_ascii(cur_item_q.data[3:0]);
				endcase
			end
			default: begin
				is_last  = 1'b1;
				out_byte = cur_item_q.data;
			end
		endcase
	end

	assign out_valid   = cur_valid_q;
	assign last_of_run = is_last;
	assign item_ready  = !cur_valid_q || (out_ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (item_ready) begin
			cur_valid_q <= item_valid;
			idx_q       <= 3'd0;
		end else if (out_ready) begin
			// advance within the current expansion
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cur_item_q <= item;
		end
	end

endmodule

@@ rtl/jsce_checker.sv @@
// Port-level checks on the escaper output stream, bound to the top level.
`include "json_string_control_escaper_core_macros.svh"

module jsce_checker import jsce_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// high hex digit of a unicode escape for codes 0x10 to 0x1f
	localparam logic [7:0] CHAR_ONE = 8'h31;

	// hold a stalled output transaction
	`JSCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_run), "stalled output changed")

	// only escape prefix bytes and the high hex digit may precede the end of a run
	`JSCE_ASSERT_ALWAYS(a_mid_run_byte, !out_valid || last_of_run || out_byte == CHAR_BACKSLASH || out_byte == CHAR_U || out_byte == CHAR_ZERO || out_byte == CHAR_ONE, "unexpected byte inside an escape")

	// a mid-run backslash is followed at once by an escape letter
	`JSCE_ASSERT_NEXT(a_after_bs, out_valid && out_ready && !last_of_run && out_byte == CHAR_BACKSLASH, out_valid && (out_byte == CHAR_N || out_byte == CHAR_R || out_byte == CHAR_T || out_byte == CHAR_U), "bad byte after escape backslash")

	// a unicode marker is followed at once by a zero digit
	`JSCE_ASSERT_NEXT(a_after_u, out_valid && out_ready && !last_of_run && out_byte == CHAR_U, out_valid && !last_of_run && out_byte == CHAR_ZERO, "bad byte after unicode marker")

endmodule

bind json_string_control_escaper_core jsce_checker u_jsce_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the JSON string control-character escaper.
`timescale 1ns / 100ps

module tb_top;
	import jsce_pkg::*;

	localparam logic [7:0] CHAR_A_LOWER = 8'h61;
	localparam logic [7:0] CHAR_LBRACE  = 8'h7b;
	localparam logic [7:0] CHAR_RBRACE  = 8'h7d;
	localparam logic [7:0] CHAR_COLON   = 8'h3a;
	localparam logic [7:0] CHAR_COMMA   = 8'h2c;
	localparam int RANDOM_ITEMS   = 420;
	localparam int HOLDOFF_AFTER  = 200;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int IDLE_LIMIT     = 4000;
	localparam int END_PAUSE      = 8;
	localparam int REPORT_MAX     = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       first_of_message = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	// Input transactions waiting to be driven, with the idle cycles before each.
	logic [7:0] pend_byte[$];
	logic       pend_first[$];
	int         pend_gap[$];
	int         items_queued = 0;
	bit         calm = 1'b0;

	// Escaped bytes the block should produce, oldest first.
	logic [7:0] esc_byte_q[$];
	logic       esc_last_q[$];

	// Predictor state.
	bit str_open = 1'b0;
	bit esc_armed = 1'b0;

	int fail_cnt = 0;
	int bytes_taken = 0;
	int idle_cycles = 0;
	int rx_cycle = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit holdoff_done = 1'b0;

	json_string_control_escaper_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.first_of_message (first_of_message),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.last_of_run      (last_of_run)
	);

	always #2 clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return CHAR_ZERO + {4'h0, v};
		end
		return CHAR_A_LOWER + {4'h0, v} - 8'd10;
	endfunction

	task automatic add_item(input logic [7:0] b, input logic first);
		pend_byte = {pend_byte, b};
		pend_first = {pend_first, first};
		if (calm || $urandom_range(0, 99) < 70) begin
			pend_gap = {pend_gap, 0};
		end else begin
			pend_gap = {pend_gap, idle_len()};
		end
		items_queued++;
	endtask

	task automatic emit(input logic [7:0] b, input logic last);
		esc_byte_q = {esc_byte_q, b};
		esc_last_q = {esc_last_q, last};
	endtask

	// Work out the escaped bytes for one accepted input byte.
	task automatic escape_byte(input logic [7:0] c, input logic first);
		if (first) begin
			str_open = 1'b0;
			esc_armed = 1'b0;
		end
		if (esc_armed) begin
			esc_armed = 1'b0;
			emit(c, 1'b1);
		end else if (!str_open) begin
			if (c == CHAR_QUOTE) str_open = 1'b1;
			emit(c, 1'b1);
		end else if (c == CHAR_BACKSLASH) begin
			esc_armed = 1'b1;
			emit(c, 1'b1);
		end else if (c == CHAR_QUOTE) begin
			str_open = 1'b0;
			emit(c, 1'b1);
		end else if (c == CHAR_LF || c == CHAR_CR || c == CHAR_TAB) begin
			emit(CHAR_BACKSLASH, 1'b0);
			emit(c == CHAR_LF ? CHAR_N : (c == CHAR_CR ? CHAR_R : CHAR_T), 1'b1);
		end else if (c < CTRL_LIMIT) begin
			emit(CHAR_BACKSLASH, 1'b0);
			emit(CHAR_U, 1'b0);
			emit(CHAR_ZERO, 1'b0);
			emit(CHAR_ZERO, 1'b0);
			emit(hex_char(c[7:4]), 1'b0);
			emit(hex_char(c[3:0]), 1'b1);
		end else begin
			emit(c, 1'b1);
		end
	endtask

	task automatic add_text_byte();
		int r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			add_item(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
		end else if (r < 55) begin
			add_item(8'($urandom_range(0, 31)), 1'b0);
		end else if (r < 67) begin
			case ($urandom_range(0, 2))
				0: b = CHAR_LF;
				1: b = CHAR_CR;
				default: b = CHAR_TAB;
			endcase
			add_item(b, 1'b0);
		end else if (r < 80) begin
			add_item(CHAR_BACKSLASH, 1'b0);
			add_item(8'($urandom_range(0, 255)), 1'b0);
		end else if (r < 92) begin
			add_item(8'($urandom_range(8'h80, 8'hff)), 1'b0);
		end else begin
			add_item(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// Quoted string with random content; now and then left unterminated.
	task automatic add_string(input int len);
		add_item(CHAR_QUOTE, 1'b0);
		repeat (len) add_text_byte();
		if ($urandom_range(0, 19) != 0) add_item(CHAR_QUOTE, 1'b0);
	endtask

	task automatic add_message();
		int nf;
		nf = $urandom_range(1, 3);
		add_item(CHAR_LBRACE, 1'b1);
		for (int i = 0; i < nf; i++) begin
			add_string($urandom_range(0, 5));
			add_item(CHAR_COLON, 1'b0);
			add_string($urandom_range(0, 10));
			add_item(i == nf - 1 ? CHAR_RBRACE : CHAR_COMMA, 1'b0);
		end
	endtask

	initial begin
		int target;
		// Directed: plain bytes outside strings, every escape kind, escaped bytes,
		// control bytes at the limits and a message start dropping string state.
		add_item(CHAR_A_LOWER, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(CHAR_QUOTE, 1'b0);
		add_item(CHAR_LF, 1'b0);
		add_item(CHAR_CR, 1'b0);
		add_item(CHAR_TAB, 1'b0);
		add_item(8'h00, 1'b0);
		add_item(8'h1f, 1'b0);
		add_item(CTRL_LIMIT, 1'b0);
		add_item(8'h80, 1'b0);
		add_item(8'hff, 1'b0);
		add_item(CHAR_BACKSLASH, 1'b0);
		add_item(CHAR_QUOTE, 1'b0);
		add_item(CHAR_BACKSLASH, 1'b0);
		add_item(8'h01, 1'b0);
		add_item(CHAR_BACKSLASH, 1'b0);
		add_item(CHAR_BACKSLASH, 1'b0);
		add_item(CHAR_QUOTE, 1'b0);
		add_item(CHAR_QUOTE, 1'b0);
		add_item(CHAR_BACKSLASH, 1'b0);
		add_item(CHAR_LF, 1'b1);
		add_item(CHAR_QUOTE, 1'b0);
		add_item(CHAR_QUOTE, 1'b1);
		add_item(CHAR_LF, 1'b0);

		target = items_queued + RANDOM_ITEMS;
		while (items_queued < target) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(5, 15))
					add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				add_message();
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_byte.size() != 0 || in_valid || esc_byte_q.size() != 0)
			@(posedge clk);
		repeat (END_PAUSE) @(posedge clk);

		if (fail_cnt == 0 && esc_byte_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Driver: hold the transaction until accepted, then offer the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				escape_byte(in_byte, first_of_message);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pend_byte.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pend_gap[0] > 0) begin
					pend_gap[0] = pend_gap[0] - 1;
					in_valid <= 1'b0;
				end else begin
					in_byte <= pend_byte.pop_front();
					first_of_message <= pend_first.pop_front();
					void'(pend_gap.pop_front());
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Receiver: random stalls, quiet stretches, and one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (!holdoff_done && bytes_taken >= HOLDOFF_AFTER) begin
				holdoff_done = 1'b1;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ((rx_cycle / 256) % 3 != 0 && $urandom_range(0, 99) < 20) begin
				stall_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: compare each output transaction with the oldest expected byte.
	always @(posedge clk) begin
		logic [7:0] exp_b;
		logic       exp_l;
		if (arst_n && out_valid && out_ready) begin
			if (esc_byte_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= REPORT_MAX)
					$display("unexpected output: byte %02h last %0b", out_byte, last_of_run);
			end else begin
				exp_b = esc_byte_q.pop_front();
				exp_l = esc_last_q.pop_front();
				if (out_byte !== exp_b || last_of_run !== exp_l) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
							exp_b, exp_l, out_byte, last_of_run);
				end
			end
		end
	end

	// Watchdog: stop when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
